/* rtl/core/iofd_pkg.sv */
// Package: format class codes, opcode format table and result word layout for the decoder.
`timescale 1ns / 1ps

package iofd_pkg;

    // Operand format classes
    typedef enum logic [4:0] {
        FC_ILL  = 5'd0,   // illegal
        FC_RAX  = 5'd1,   // ra, addr, rx
        FC_RAC  = 5'd2,   // ra, constant addr, rx
        FC_NAX  = 5'd3,   // n, addr, rx
        FC_N1X  = 5'd4,   // n+1, addr, rx
        FC_RARB = 5'd5,   // ra, rb
        FC_NRB  = 5'd6,   // n, rb
        FC_RBN1 = 5'd7,   // rb, n+1
        FC_RAN1 = 5'd8,   // ra, n+1
        FC_ICR  = 5'd9,   // instruction counter relative
        FC_IML  = 5'd10,  // immediate long
        FC_BRX  = 5'd11,  // base relative indexed
        FC_BRD  = 5'd12,  // base relative displacement
        FC_XIO  = 5'd13,
        FC_BIF  = 5'd14,
        FC_CJ   = 5'd15,  // conditional jump
        FC_BEX  = 5'd16,
        FC_LST  = 5'd17,
        FC_RAO  = 5'd18,  // ra only
        FC_NONE = 5'd19
    } fmt_t;

    typedef struct packed {
        logic one;
        logic two;
    } ext_enable_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [4:0]        pad;
        logic [15:0]       operand_word;
        logic              two_addresses;
        logic              index_used;
        logic signed [7:0] branch_offset;
        logic [7:0]        displacement;
        logic [3:0]        base_reg;
        logic [4:0]        count_value;
        logic [3:0]        reg_b;
        logic [3:0]        reg_a;
        fmt_t              format_class;
        logic [1:0]        word_count;
        logic              illegal;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

    localparam logic [7:0] OP_IML  = 8'h4A;
    localparam logic [7:0] OP_NOPB = 8'hFF;
    localparam logic [7:0] OP_F5   = 8'hF5;
    localparam logic [7:0] LO_NOP  = 8'h00;
    localparam logic [7:0] LO_BPT  = 8'hFF;
    localparam logic [3:0] SUBOP_C = 4'hC;

    // Base opcode table indexed by the high byte
    localparam fmt_t FMT_TABLE [256] = '{
        FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD,
        FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD,
        FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD,
        FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD,
        FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD,
        FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD,
        FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD,
        FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD, FC_BRD,
        // 40
        FC_BRX, FC_BRX, FC_BRX, FC_BRX, FC_ILL, FC_ILL, FC_ILL, FC_ILL,
        FC_XIO, FC_RAX, FC_IML, FC_ILL, FC_ILL, FC_ILL, FC_ILL, FC_BIF,
        // 50
        FC_NAX, FC_NRB, FC_NAX, FC_NAX, FC_NRB, FC_NAX, FC_NAX, FC_NRB,
        FC_NAX, FC_NAX, FC_RARB, FC_ILL, FC_RARB, FC_ILL, FC_RARB, FC_ILL,
        // 60
        FC_RBN1, FC_RBN1, FC_RBN1, FC_RBN1, FC_ILL, FC_RBN1, FC_RBN1, FC_RBN1,
        FC_RBN1, FC_ILL, FC_RARB, FC_RARB, FC_RARB, FC_RARB, FC_RARB, FC_RARB,
        // 70
        FC_CJ, FC_CJ, FC_RAC, FC_RAC, FC_ICR, FC_ICR, FC_ICR, FC_BEX,
        FC_ICR, FC_ICR, FC_ICR, FC_ICR, FC_LST, FC_LST, FC_RAC, FC_RAO,
        // 80
        FC_RAX, FC_RARB, FC_RAN1, FC_RAN1, FC_RAX, FC_RAX, FC_RAX, FC_RARB,
        FC_RAX, FC_NAX, FC_RAX, FC_RAX, FC_RAX, FC_RARB, FC_RARB, FC_RARB,
        // 90
        FC_RAX, FC_NAX, FC_NAX, FC_RARB, FC_RAX, FC_ILL, FC_RAX, FC_RAX,
        FC_RAX, FC_NAX, FC_RAX, FC_RAX, FC_RAX, FC_RAX, FC_RAX, FC_RARB,
        // A0
        FC_RAX, FC_RARB, FC_RAN1, FC_N1X, FC_RARB, FC_RARB, FC_RAX, FC_RARB,
        FC_RAX, FC_RARB, FC_RAX, FC_RARB, FC_RARB, FC_ILL, FC_ILL, FC_ILL,
        // B0
        FC_RAX, FC_RARB, FC_RAN1, FC_N1X, FC_RARB, FC_RARB, FC_RAX, FC_RARB,
        FC_RAX, FC_RARB, FC_RAX, FC_RARB, FC_RARB, FC_ILL, FC_ILL, FC_ILL,
        // C0
        FC_RAX, FC_RARB, FC_RAN1, FC_RAN1, FC_RAX, FC_RARB, FC_RAX, FC_RARB,
        FC_RAX, FC_RARB, FC_RAX, FC_RARB, FC_ILL, FC_ILL, FC_ILL, FC_ILL,
        // D0
        FC_RAX, FC_RARB, FC_RAN1, FC_RAN1, FC_RAX, FC_RARB, FC_RAX, FC_RARB,
        FC_RAX, FC_RARB, FC_RAX, FC_RARB, FC_ILL, FC_ILL, FC_ILL, FC_ILL,
        // E0
        FC_RAX, FC_RARB, FC_RAX, FC_RARB, FC_RAX, FC_RARB, FC_RAX, FC_RARB,
        FC_RARB, FC_RARB, FC_RARB, FC_RARB, FC_RAO, FC_RARB, FC_ILL, FC_ILL,
        // F0
        FC_RAX, FC_RARB, FC_RAN1, FC_RAN1, FC_RAX, FC_ILL, FC_RAX, FC_RARB,
        FC_RAX, FC_RARB, FC_RAX, FC_RARB, FC_ILL, FC_ILL, FC_ILL, FC_NONE
    };

endpackage

/* rtl/core/iofd_cfg.sv */
// Extension enable registers written through the plain configuration port.
`timescale 1ns / 1ps

module iofd_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_addr,
    input  logic                 cfg_wdata,
    output iofd_pkg::ext_enable_t ext_enable
);
    import iofd_pkg::*;

    ext_enable_t enable_reg;
    ext_enable_t enable_next;

    always_comb begin
        enable_next = enable_reg;
        if (cfg_wr_en) begin
            if (cfg_addr == 1'b0) begin
                enable_next.one = cfg_wdata;
            end else begin
                enable_next.two = cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= '0;
        end else begin
            enable_reg <= enable_next;
        end
    end

    assign ext_enable = enable_reg;

endmodule

/* rtl/core/iofd_decode.sv */
// Combinational opcode decode: table lookup, extension gating, legality and field extraction.
`timescale 1ns / 1ps

module iofd_decode (
    input  logic [15:0]           instr_word,
    input  logic [15:0]           ext_word,
    input  iofd_pkg::ext_enable_t ext_enable,
    output iofd_pkg::result_t     result
);
    import iofd_pkg::*;

    logic [7:0] hi;
    logic [7:0] lo;
    logic [3:0] ua;
    logic [3:0] ub;
    logic       e_any;
    fmt_t       fmt_base;
    fmt_t       fmt;

    assign hi    = instr_word[15:8];
    assign lo    = instr_word[7:0];
    assign ua    = instr_word[7:4];
    assign ub    = instr_word[3:0];
    assign e_any = ext_enable.one | ext_enable.two;

    // optional extension opcodes override the base table
    always_comb begin
        case (hi)
            8'h4D, 8'h4E:        fmt_base = ext_enable.one ? FC_RAO : FC_ILL;
            8'h95, 8'hAD, 8'hBD: fmt_base = e_any ? FC_RARB : FC_ILL;
            8'hAE, 8'hBE:        fmt_base = e_any ? FC_RAX : FC_ILL;
            8'hCC, 8'hCD, 8'hCE: fmt_base = ext_enable.two ? FC_RAX : FC_ILL;
            8'hDC, 8'hDD, 8'hDE: fmt_base = e_any ? FC_RAX : FC_ILL;
            8'hDF:               fmt_base = ext_enable.one ? FC_RAX : FC_ILL;
            8'hF5:               fmt_base = ext_enable.one ? FC_IML : FC_ILL;
            8'hFC:               fmt_base = ext_enable.one ? FC_RARB : FC_ILL;
            8'hFD:               fmt_base = ext_enable.one ? FC_RAX : FC_ILL;
            default:             fmt_base = FMT_TABLE[hi];
        endcase
    end

    // reject bad sub-op and must-be-zero fields
    always_comb begin
        fmt = fmt_base;
        case (fmt_base)
            FC_IML: begin
                if (hi != OP_F5 && (ub == 4'h0 || ub >= SUBOP_C)) fmt = FC_ILL;
            end
            FC_BEX, FC_LST: begin
                if (ua != 4'h0) fmt = FC_ILL;
            end
            FC_RAO: begin
                if (ub != 4'h0) fmt = FC_ILL;
            end
            FC_NONE: begin
                if (lo != LO_NOP && lo != LO_BPT) fmt = FC_ILL;
            end
            default: begin
                fmt = fmt_base;
            end
        endcase
    end

    always_comb begin
        logic two_word;
        logic takes_index;
        two_word    = 1'b0;
        takes_index = 1'b0;
        result      = '0;
        case (fmt)
            FC_RAX, FC_RAC, FC_NAX, FC_N1X, FC_XIO, FC_BIF, FC_CJ, FC_LST: begin
                two_word    = 1'b1;
                takes_index = 1'b1;
            end
            FC_IML: begin
                two_word = 1'b1;
            end
            FC_BRX: begin
                takes_index = 1'b1;
            end
            default: begin
                two_word = 1'b0;
            end
        endcase

        if (fmt == FC_ILL) begin
            result.illegal = 1'b1;
        end else begin
            result.word_count   = two_word ? 2'd2 : 2'd1;
            result.format_class = fmt;
            result.reg_a        = ua;
            result.reg_b        = ub;
            if (fmt == FC_N1X || fmt == FC_RBN1) result.count_value = {1'b0, ua} + 5'd1;
            if (fmt == FC_RAN1)                  result.count_value = {1'b0, ub} + 5'd1;
            if (fmt == FC_BRX || fmt == FC_BRD)  result.base_reg    = {2'b11, hi[1:0]};
            if (fmt == FC_BRD)                   result.displacement = lo;
            if (fmt == FC_ICR)                   result.branch_offset = lo;
            if (takes_index)                     result.index_used = (ub != 4'h0);
            if (fmt == FC_BIF)                   result.two_addresses = ua[2];
            if (two_word)                        result.operand_word = ext_word;
        end
    end

endmodule

/* rtl/core/isa_opcode_format_decoder.sv */
// Top level of the instruction format decoder: input register, decode, result register.
`timescale 1ns / 1ps

// Instruction format decoder. Each input word carries one 16-bit instruction
// word and the word that follows it; each output word carries the decoded
// format class, instruction length (0 when illegal), legality flag and the
// operand fields. The block is a two-register pipeline: the input word is
// captured, decoded by short logic, and the result is held in an output
// register until taken. One word is accepted every cycle when the output side
// keeps up, and a word passes the input and then the output register. A
// stalled output holds its result while the input register still takes one
// more word. The two extension enables come from the configuration port
// (index 0 first set, index 1 second set) and reset to disabled; write them
// only while no word is in flight.
module isa_opcode_format_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic        cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] instr_word, [31:16] ext_word
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] illegal, [2:1] word_count, [7:3] format_class, [11:8] reg_a,
    // [15:12] reg_b, [20:16] count_value, [24:21] base_reg,
    // [32:25] displacement, [40:33] branch_offset, [41] index_used,
    // [42] two_addresses, [58:43] operand_word, [63:59] zero
    output logic [63:0] m_tdata
);
    import iofd_pkg::*;

    ext_enable_t ext_enable;
    result_t     dec_result;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [15:0] instr_reg;
    logic [15:0] extw_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     result_reg;
    logic        advance;

    iofd_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .ext_enable (ext_enable)
    );

    iofd_decode u_decode (
        .instr_word (instr_reg),
        .ext_word   (extw_reg),
        .ext_enable (ext_enable),
        .result     (dec_result)
    );

    // advance the decode stage whenever the output register is empty or drains
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance) out_valid_next = in_valid_reg;
        if (s_tready) in_valid_next = s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: capture on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            instr_reg <= s_tdata[15:0];
            extw_reg  <= s_tdata[31:16];
        end
        if (advance && in_valid_reg) begin
            result_reg <= dec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg[RESULT_W-1:0];

endmodule

/* rtl/core/iofd_checker.sv */
// Port-level checker for the instruction format decoder and its bind.
`timescale 1ns / 1ps

module iofd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // hold a stalled result word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // drop all fields of an illegal word
    a_illegal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[63:1] == 63'd0)
        else $error("illegal word carries nonzero fields");

    a_legal_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == 2'd1 || m_tdata[2:1] == 2'd2)
        else $error("legal word with bad length");

    a_one_word_operand: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:1] != 2'd2 |-> m_tdata[58:43] == 16'd0)
        else $error("operand word passed on a short instruction");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind isa_opcode_format_decoder iofd_checker u_iofd_checker (.*);
